[src/slbs_pkg.sv]
// Package: types, constants and pattern tables of the status LED blink sequencer.
package slbs_pkg;

  localparam int unsigned StatusW  = 3;
  localparam int unsigned StepW    = 2;
  localparam int unsigned ElapsedW = 12;
  localparam int unsigned CountW   = 3;

  localparam int unsigned NumPatterns = 5;
  localparam int unsigned MaxSteps    = 4;

  localparam logic [StatusW-1:0] StatusBoot   = 3'd0;
  localparam logic [StatusW-1:0] StatusSetup  = 3'd1;
  localparam logic [StatusW-1:0] StatusWifi   = 3'd2;
  localparam logic [StatusW-1:0] StatusOnline = 3'd3;
  localparam logic [StatusW-1:0] StatusOk     = 3'd4;

  typedef struct packed {
    logic [StatusW-1:0]  shown;
    logic [StepW-1:0]    step;
    logic [ElapsedW-1:0] elapsed;
  } slbs_state_t;

  typedef struct packed {
    logic             led_level;
    logic [StepW-1:0] step_now;
  } slbs_result_t;

  function automatic logic [CountW-1:0] pat_count(logic [StatusW-1:0] pat);
    logic [CountW-1:0] n;
    case (pat)
      StatusBoot:   n = 3'd1;
      StatusSetup:  n = 3'd2;
      StatusWifi:   n = 3'd2;
      StatusOnline: n = 3'd4;
      StatusOk:     n = 3'd2;
      default:      n = 3'd1;
    endcase
    return n;
  endfunction

  // Steps actually played, clamped to MaxSteps and to at least 1
  function automatic logic [CountW-1:0] seq_steps(logic [StatusW-1:0] pat);
    logic [CountW-1:0] n;
    n = pat_count(pat);
    if (MaxSteps < 32'(n)) begin
      n = CountW'(MaxSteps);
    end
    if (n == '0) begin
      n = CountW'(1);
    end
    return n;
  endfunction

  function automatic logic pat_level(logic [StatusW-1:0] pat, logic [StepW-1:0] step);
    logic lvl;
    lvl = (step == 2'd0) || ((pat == StatusOnline) && (step == 2'd2));
    return lvl;
  endfunction

  function automatic logic [ElapsedW-1:0] pat_len(logic [StatusW-1:0] pat,
                                                  logic [StepW-1:0] step);
    logic [ElapsedW-1:0] len;
    len = '0;
    case (pat)
      StatusBoot: begin
        if (step == 2'd0) len = 12'd250;
      end
      StatusSetup: begin
        if (step == 2'd0 || step == 2'd1) len = 12'd500;
      end
      StatusWifi: begin
        if (step == 2'd0 || step == 2'd1) len = 12'd100;
      end
      StatusOnline: begin
        case (step)
          2'd0:    len = 12'd80;
          2'd1:    len = 12'd200;
          2'd2:    len = 12'd80;
          default: len = 12'd1600;
        endcase
      end
      StatusOk: begin
        if (step == 2'd0) len = 12'd60;
        else if (step == 2'd1) len = 12'd2940;
      end
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

[src/slbs_if.sv]
// Interfaces: status request channel and LED result channel.
interface slbs_status_if
  import slbs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

interface slbs_led_if
  import slbs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             led_level;
  logic [StepW-1:0] step_now;

  modport source (output valid, output led_level, output step_now, input ready);
  modport sink (input valid, input led_level, input step_now, output ready);
endinterface

[src/slbs_step_logic.sv]
// Per-tick update: status check, result forming and step advance.
module slbs_step_logic
  import slbs_pkg::*;
(
  input  logic [StatusW-1:0] status_i,
  input  logic               active_low_i,
  input  slbs_state_t        state_i,
  output slbs_state_t        state_o,
  output slbs_result_t       result_o
);

  logic                restart;
  logic [StatusW-1:0]  shown;
  logic [StatusW-1:0]  pat;
  logic [StepW-1:0]    step;
  logic [ElapsedW-1:0] elapsed;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [CountW-1:0]   n_steps;
  logic [CountW-1:0]   step_inc;

  always_comb begin
    restart = (32'(status_i) < NumPatterns) && (status_i != state_i.shown);
    shown   = restart ? status_i : state_i.shown;
    step    = restart ? '0 : state_i.step;
    elapsed = restart ? '0 : state_i.elapsed;

    pat     = (32'(shown) < NumPatterns) ? shown : StatusBoot;
    n_steps = seq_steps(pat);
    if ({1'b0, step} >= n_steps) begin
      step    = '0;
      elapsed = '0;
    end

    result_o.led_level = pat_level(pat, step) ^ active_low_i;
    result_o.step_now  = step;

    elapsed_inc = elapsed + ElapsedW'(1);
    step_inc    = {1'b0, step} + CountW'(1);

    state_o.shown   = shown;
    state_o.step    = step;
    state_o.elapsed = elapsed_inc;
    if (elapsed_inc >= pat_len(pat, step)) begin
      state_o.elapsed = '0;
      state_o.step    = (step_inc >= n_steps) ? '0 : step_inc[StepW-1:0];
    end
  end

endmodule

[src/status_led_blink_sequencer.sv]
// Accepted requests pass the input register, then the result register.
// Throughput: one tick request per cycle while results are taken; a new one is
// still taken into an empty input register while a stalled result waits.
// Reset: asynchronous, active low; shows the boot pattern at step 0 with
// zero elapsed time, active_low cleared, both pipeline stages empty.
module status_led_blink_sequencer
  import slbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  slbs_status_if.sink          status_i,
  slbs_led_if.source           led_o
);

  logic               active_low_q;
  logic               in_valid_q;
  logic [StatusW-1:0] status_q;
  logic               in_ready;
  logic               advance;
  logic               out_valid_q;
  slbs_result_t       result_d;
  slbs_result_t       result_q;
  slbs_state_t        state_d;
  slbs_state_t        state_q;

  assign advance        = in_valid_q && (!out_valid_q || led_o.ready);
  assign in_ready       = !in_valid_q || advance;
  assign status_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      active_low_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= status_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_i.valid && in_ready) begin
      status_q <= status_i.status;
    end
  end

  slbs_step_logic u_step_logic (
    .status_i     (status_q),
    .active_low_i (active_low_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (led_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign led_o.valid     = out_valid_q;
  assign led_o.led_level = result_q.led_level;
  assign led_o.step_now  = result_q.step_now;

  // State invariants
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.shown) < NumPatterns)
    else $error("shown status out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, state_q.step} < seq_steps(state_q.shown))
    else $error("step index beyond pattern length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.elapsed < pat_len(state_q.shown, state_q.step))
    else $error("elapsed time reached step length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !led_o.ready) |=> $stable(state_q))
    else $error("state moved while result stage stalled");

endmodule

[tb/sv/testbench.sv]
// Status LED blink sequencer testbench: directed and random ticks, predicted LED levels, scoreboard checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slbs_pkg::*;

  localparam logic [StatusW-1:0] StatusRsvd5 = 3'd5;
  localparam logic [StatusW-1:0] StatusRsvd6 = 3'd6;
  localparam logic [StatusW-1:0] StatusRsvd7 = 3'd7;

  localparam int unsigned HoldCycles = 300;

  localparam logic [StatusW-1:0] DirectedPlan [24] = '{
    StatusBoot, StatusBoot, StatusSetup, StatusSetup, StatusRsvd5, StatusSetup,
    StatusWifi, StatusRsvd6, StatusWifi, StatusOnline, StatusOnline, StatusRsvd7,
    StatusOnline, StatusOk, StatusOk, StatusRsvd5, StatusRsvd6, StatusRsvd7,
    StatusOk, StatusBoot, StatusWifi, StatusOk, StatusOnline, StatusBoot
  };

  typedef struct packed {
    logic             led;
    logic [StepW-1:0] step;
  } led_req_t;

  class BlinkScoreboard;
    bit                 invert;
    logic [StatusW-1:0] shown;
    int unsigned        step;
    int unsigned        elapsed;
    led_req_t           expected_q[$];
    int unsigned        ticks, results, restarts, ignored, wraps, mismatches;

    int unsigned step_count [5]    = '{1, 2, 2, 4, 2};
    bit          step_on    [5][4] = '{'{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0},
                                       '{1, 0, 1, 0}, '{1, 0, 0, 0}};
    int unsigned step_len   [5][4] = '{'{250, 0, 0, 0}, '{500, 500, 0, 0},
                                       '{100, 100, 0, 0}, '{80, 200, 80, 1600},
                                       '{60, 2940, 0, 0}};

    function new();
      invert  = 1'b0;
      shown   = StatusBoot;
      step    = 0;
      elapsed = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_tick(logic [StatusW-1:0] req);
      int unsigned pat;
      int unsigned n;
      led_req_t    want;
      ticks++;
      if (req >= NumPatterns) begin
        ignored++;
      end else if (req != shown) begin
        shown   = req;
        step    = 0;
        elapsed = 0;
        restarts++;
      end
      pat = shown;
      n   = step_count[pat];
      if (n > MaxSteps) begin
        n = MaxSteps;
      end
      if (step >= n) begin
        step    = 0;
        elapsed = 0;
      end
      want.led  = step_on[pat][step] ^ invert;
      want.step = StepW'(step);
      expected_q.push_back(want);
      elapsed = (elapsed + 1) % 4096;
      if (elapsed >= step_len[pat][step]) begin
        elapsed = 0;
        step++;
        if (step >= n) begin
          step = 0;
          wraps++;
        end
      end
    endfunction

    function void check_led(logic lvl, logic [StepW-1:0] st);
      led_req_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result led=%b step=%0d", $time, lvl, st);
        end
      end else begin
        want = expected_q.pop_front();
        if (want.led !== lvl || want.step !== st) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d mismatch: expected led=%b step=%0d, got led=%b step=%0d",
                     $time, results, want.led, want.step, lvl, st);
          end
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  slbs_status_if status_ch ();
  slbs_led_if    led_ch ();

  status_led_blink_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status_ch),
    .led_o       (led_ch)
  );

  BlinkScoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          pressure_armed;
  bit          pressure_done;
  int unsigned hold_left;
  bit          polarity_seen [2];

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #(500_000);
    $display("Verification failed");
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    led_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left     = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        led_ch.ready <= 1'b0;
      end else begin
        led_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && led_ch.valid && led_ch.ready) begin
      sb.check_led(led_ch.led_level, led_ch.step_now);
    end
  end

  task automatic send_tick(input logic [StatusW-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      status_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    status_ch.valid  <= 1'b1;
    status_ch.status <= s;
    do begin
      @(posedge clk_i);
    end while (!status_ch.ready);
    sb.note_tick(s);
  endtask

  task automatic drain();
    @(negedge clk_i);
    status_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_polarity(input bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.invert        = v;
    polarity_seen[v] = 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // runs of one status with random length, reserved codes sprinkled in, some noise bursts
  task automatic run_random(input int unsigned n_items, input int unsigned arm_after);
    int unsigned         sent;
    int unsigned         run_len;
    int unsigned         pick;
    logic [StatusW-1:0]  s;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        run_len = $urandom_range(1, 8);
      end else if (pick < 55) begin
        run_len = $urandom_range(1, 40);
      end else if (pick < 88) begin
        run_len = $urandom_range(41, 320);
      end else begin
        run_len = $urandom_range(321, 1100);
      end
      s = StatusW'($urandom_range(StatusBoot, StatusOk));
      for (int unsigned i = 0; i < run_len && sent < n_items; i++) begin
        if (pick < 10) begin
          send_tick(StatusW'($urandom_range(StatusBoot, StatusRsvd7)));
        end else if ($urandom_range(0, 99) < 6) begin
          send_tick(StatusW'($urandom_range(StatusRsvd5, StatusRsvd7)));
        end else begin
          send_tick(s);
        end
        sent++;
        if (arm_after != 0 && sent == arm_after) begin
          pressure_armed = 1'b1;
        end
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    status_ch.valid  = 1'b0;
    status_ch.status = StatusBoot;
    pressure_armed   = 1'b0;
    pressure_done    = 1'b0;
    hold_left        = 0;
    tx_idle_pct      = 24;
    rx_idle_pct      = 52;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_polarity(1'b1);
    foreach (DirectedPlan[i]) begin
      send_tick(DirectedPlan[i]);
    end
    drain();

    write_polarity(1'b0);
    run_random(450, 0);
    drain();

    tx_idle_pct = 52;
    rx_idle_pct = 24;
    write_polarity(1'b1);
    run_random(450, 120);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_polarity(1'b0);
    run_random(450, 0);
    drain();

    $display("Covered %0d ticks and %0d results: %0d pattern restarts, %0d reserved codes,",
             sb.ticks, sb.results, sb.restarts, sb.ignored);
    $display("%0d pattern wraps, polarity high/low seen %0b/%0b, %0d mismatches",
             sb.wraps, polarity_seen[0], polarity_seen[1], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/slbs_pkg.sv
src/slbs_if.sv
src/slbs_step_logic.sv
src/status_led_blink_sequencer.sv
tb/sv/testbench.sv
